// ===== src/rau_pkg.sv =====
package rau_pkg;

	localparam int OW = 32;
	localparam int WW = 64;

	typedef enum logic [2:0] {
		CMD_NORM,
		CMD_ADD,
		CMD_SUB,
		CMD_MUL,
		CMD_DIV,
		CMD_EQ,
		CMD_LT,
		CMD_NONE
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_ZDEN,
		STAT_DIV0,
		STAT_OVF
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIVM,
		ST_DIVD,
		ST_RET,
		ST_MUL,
		ST_COMB
	} state_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_R
	} phase_t;

	typedef struct packed {
		logic          neg;
		logic [OW-1:0] mag;
	} sx_t;

	// sign-extend the low OW bits and split into sign and magnitude
	function automatic sx_t sext(input logic [31:0] raw);
		logic [OW-1:0] v;
		sx_t r;
		v = raw[OW-1:0];
		r.neg = v[OW-1];
		r.mag = r.neg ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

// ===== src/rational_arith_unit_top.sv =====
// Work goes through the shared reducer: a binary gcd loop (one shift or subtract
// a cycle) and a bit-per-cycle divider for numerator and denominator, run once per
// operand and once more for the result of add, subtract, multiply and nonzero divide.
// Unused-command and zero-denominator items finish from idle without entering the
// reducer. One item at a time; busy is high meanwhile.
// Reset clears the sequencer and the done strobe; results are held until the next done.
module rational_arith_unit_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               done,
	output logic signed [63:0] res_num,
	output logic [62:0]        res_den,
	output logic               cmp_true,
	output logic [1:0]         status
);
	import rau_pkg::*;

	state_t        state_q, state_nx;
	phase_t        phase_q;
	cmd_t          cmd_q, cmd_in;
	logic [31:0]   bnum_q, bden_q;
	logic [WW-1:0] rx_q, ry_q, g_q, rmag_q, rden_q, dq_q, drem_q;
	logic [5:0]    rk_q, dcnt_q;
	logic          rneg_q;
	logic          aneg_q, bneg_q;
	logic [OW-1:0] amag_q, aden_q, bmg_q, bdn_q;
	logic [WW-1:0] p_q [4];
	logic [1:0]    midx_q;
	logic          done_q;
	logic signed [63:0] num_q;
	logic [62:0]   den_q;
	logic          cmp_q;
	logic [1:0]    stat_q;

	sx_t sa_n, sa_d, sb_d, rb_n, rb_d;
	logic          zden, take;
	logic [WW:0]   rsh;
	logic          ge;
	logic [WW-1:0] rem_nx, q_nx;
	logic [OW-1:0] mul_x, mul_y;
	logic [2*OW-1:0] prod;
	logic          cneg;
	logic [WW-1:0] cmag, cden;
	logic signed [WW-1:0] lt_l, lt_r;
	logic          fin_v, fin_cmp, ovf;
	logic [WW-1:0] fin_num;
	logic [62:0]   fin_den;
	stat_t         fin_stat;

	// decode the incoming item
	assign cmd_in = cmd_t'(cmd);
	assign take   = start && (state_q == ST_IDLE);
	always_comb begin
		sa_n = sext(a_num);
		sa_d = sext(a_den);
		sb_d = sext(b_den);
		rb_n = sext(bnum_q);
		rb_d = sext(bden_q);
		zden = (sa_d.mag == '0) || ((cmd_in != CMD_NORM) && (sb_d.mag == '0));
	end

	// one restoring divider step
	always_comb begin
		rsh    = {drem_q, dq_q[WW-1]};
		ge     = rsh >= {1'b0, g_q};
		rem_nx = ge ? WW'(rsh - {1'b0, g_q}) : rsh[WW-1:0];
		q_nx   = {dq_q[WW-2:0], ge};
	end

	// select multiplier operands
	always_comb begin
		case (midx_q)
			2'd0: begin mul_x = amag_q; mul_y = bdn_q;  end
			2'd1: begin mul_x = bmg_q;  mul_y = aden_q; end
			2'd2: begin mul_x = aden_q; mul_y = bdn_q;  end
			default: begin mul_x = amag_q; mul_y = bmg_q; end
		endcase
		prod = mul_x * mul_y;
	end

	// combine the products into an unreduced result
	always_comb begin
		cneg = aneg_q ^ bneg_q;
		cmag = p_q[3];
		cden = p_q[2];
		case (cmd_q)
			CMD_ADD, CMD_SUB: begin
				cden = p_q[2];
				if (aneg_q == bneg_q) begin
					cneg = aneg_q;
					cmag = p_q[0] + p_q[1];
				end else if (p_q[0] >= p_q[1]) begin
					cneg = aneg_q;
					cmag = p_q[0] - p_q[1];
				end else begin
					cneg = bneg_q;
					cmag = p_q[1] - p_q[0];
				end
			end
			CMD_DIV: begin
				cmag = p_q[0];
				cden = p_q[1];
			end
			default: begin
				cmag = p_q[3];
				cden = p_q[2];
			end
		endcase
		lt_l = aneg_q ? -$signed(p_q[0]) : $signed(p_q[0]);
		lt_r = bneg_q ? -$signed(p_q[1]) : $signed(p_q[1]);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd_in == CMD_NONE || zden)
						state_nx = ST_IDLE;
					else
						state_nx = ST_GCD;
				end
			end
			ST_GCD: begin
				if (rx_q == '0 || ry_q == '0)
					state_nx = ST_DIVM;
			end
			ST_DIVM: begin
				if (dcnt_q == '0)
					state_nx = ST_DIVD;
			end
			ST_DIVD: begin
				if (dcnt_q == '0)
					state_nx = ST_RET;
			end
			ST_RET: begin
				case (phase_q)
					PH_A: state_nx = (cmd_q == CMD_NORM) ? ST_IDLE : ST_GCD;
					PH_B: state_nx = ST_MUL;
					default: state_nx = ST_IDLE;
				endcase
			end
			ST_MUL: begin
				if (midx_q == 2'd3)
					state_nx = ST_COMB;
			end
			ST_COMB: begin
				if ((cmd_q == CMD_DIV && bmg_q == '0) || cmd_q == CMD_EQ || cmd_q == CMD_LT)
					state_nx = ST_IDLE;
				else
					state_nx = ST_GCD;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs and finished result
	always_comb begin
		busy     = (state_q != ST_IDLE);
		fin_v    = 1'b0;
		fin_num  = '0;
		fin_den  = '0;
		fin_cmp  = 1'b0;
		fin_stat = STAT_OK;
		ovf = (!rneg_q && rmag_q[WW-1]) || (rneg_q && rmag_q[WW-1] && (|rmag_q[WW-2:0]))
			|| rden_q[WW-1];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd_in == CMD_NONE) begin
						fin_v = 1'b1;
					end else if (zden) begin
						fin_v    = 1'b1;
						fin_stat = STAT_ZDEN;
					end
				end
			end
			ST_RET: begin
				if (phase_q == PH_R || (phase_q == PH_A && cmd_q == CMD_NORM)) begin
					fin_v = 1'b1;
					if (ovf) begin
						fin_stat = STAT_OVF;
					end else begin
						fin_num = rneg_q ? (~rmag_q + 1'b1) : rmag_q;
						fin_den = rden_q[62:0];
					end
				end
			end
			ST_COMB: begin
				if (cmd_q == CMD_DIV && bmg_q == '0) begin
					fin_v    = 1'b1;
					fin_stat = STAT_DIV0;
				end else if (cmd_q == CMD_EQ) begin
					fin_v   = 1'b1;
					fin_cmp = (aneg_q == bneg_q) && (amag_q == bmg_q) && (aden_q == bdn_q);
				end else if (cmd_q == CMD_LT) begin
					fin_v   = 1'b1;
					fin_cmp = lt_l < lt_r;
				end
			end
			default: fin_v = 1'b0;
		endcase
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_A;
			midx_q  <= '0;
			dcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= fin_v;
			case (state_q)
				ST_IDLE: phase_q <= PH_A;
				ST_GCD: dcnt_q <= '1;
				ST_DIVM: dcnt_q <= dcnt_q - 1'b1;
				ST_DIVD: dcnt_q <= dcnt_q - 1'b1;
				ST_RET: begin
					midx_q <= '0;
					if (phase_q == PH_A)
						phase_q <= PH_B;
				end
				ST_MUL: midx_q <= midx_q + 1'b1;
				ST_COMB: phase_q <= PH_R;
				default: midx_q <= midx_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fin_v) begin
			num_q  <= $signed(fin_num);
			den_q  <= fin_den;
			cmp_q  <= fin_cmp;
			stat_q <= fin_stat;
		end
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd_q  <= cmd_in;
					bnum_q <= b_num;
					bden_q <= b_den;
					rneg_q <= (sa_n.neg ^ sa_d.neg) && (sa_n.mag != '0);
					rmag_q <= WW'(sa_n.mag);
					rden_q <= WW'(sa_d.mag);
					rx_q   <= WW'(sa_n.mag);
					ry_q   <= WW'(sa_d.mag);
					rk_q   <= '0;
				end
			end
			ST_GCD: begin
				if (rx_q == '0 || ry_q == '0) begin
					g_q    <= (rx_q | ry_q) << rk_q;
					dq_q   <= rmag_q;
					drem_q <= '0;
				end else if (!rx_q[0] && !ry_q[0]) begin
					rx_q <= rx_q >> 1;
					ry_q <= ry_q >> 1;
					rk_q <= rk_q + 1'b1;
				end else if (!rx_q[0]) begin
					rx_q <= rx_q >> 1;
				end else if (!ry_q[0]) begin
					ry_q <= ry_q >> 1;
				end else if (rx_q >= ry_q) begin
					rx_q <= rx_q - ry_q;
				end else begin
					ry_q <= ry_q - rx_q;
				end
			end
			ST_DIVM: begin
				if (dcnt_q == '0) begin
					rmag_q <= q_nx;
					dq_q   <= rden_q;
					drem_q <= '0;
				end else begin
					dq_q   <= q_nx;
					drem_q <= rem_nx;
				end
			end
			ST_DIVD: begin
				if (dcnt_q == '0) begin
					rden_q <= q_nx;
				end else begin
					dq_q   <= q_nx;
					drem_q <= rem_nx;
				end
			end
			ST_RET: begin
				if (phase_q == PH_A) begin
					aneg_q <= rneg_q;
					amag_q <= rmag_q[OW-1:0];
					aden_q <= rden_q[OW-1:0];
					rneg_q <= (rb_n.neg ^ rb_d.neg) && (rb_n.mag != '0);
					rmag_q <= WW'(rb_n.mag);
					rden_q <= WW'(rb_d.mag);
					rx_q   <= WW'(rb_n.mag);
					ry_q   <= WW'(rb_d.mag);
					rk_q   <= '0;
				end else if (phase_q == PH_B) begin
					bneg_q <= (cmd_q == CMD_SUB && rmag_q != '0) ? ~rneg_q : rneg_q;
					bmg_q  <= rmag_q[OW-1:0];
					bdn_q  <= rden_q[OW-1:0];
				end
			end
			ST_MUL: p_q[midx_q] <= WW'(prod);
			ST_COMB: begin
				rneg_q <= cneg && (cmag != '0);
				rmag_q <= cmag;
				rden_q <= cden;
				rx_q   <= cmag;
				ry_q   <= cden;
				rk_q   <= '0;
			end
			default: rk_q <= rk_q;
		endcase
	end

	assign done     = done_q;
	assign res_num  = num_q;
	assign res_den  = den_q;
	assign cmp_true = cmp_q;
	assign status   = stat_q;

endmodule

// ===== src/rau_checker.sv =====
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [63:0] res_num,
	input logic [62:0] res_den,
	input logic        cmp_true,
	input logic [1:0]  status
);
	import rau_pkg::*;

	// show a result only after an item was offered or work was under way
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy)) else $error("result without an item");

	// drop payload on any error status
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |-> res_num == '0 && res_den == '0 && !cmp_true)
		else $error("error result carries data");

	// a zero denominator only comes with a zero numerator
	a_den_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res_den == '0) |-> res_num == '0)
		else $error("nonzero numerator over zero denominator");

	// finish before taking the next item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.res_num  (res_num),
	.res_den  (res_den),
	.cmp_true (cmp_true),
	.status   (status)
);
